FILE: rtl/long_press_and_multi_tap_qualifier_macros.svh
// assertion macros for the long-press and multi-tap qualifier
// depends on nothing; included by the files that carry assertions
`ifndef LONG_PRESS_AND_MULTI_TAP_QUALIFIER_MACROS_SVH
`define LONG_PRESS_AND_MULTI_TAP_QUALIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpmt assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define LPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpmt assertion failed: next-cycle implication");

`endif

FILE: rtl/lpmt_pkg.sv
// shared types, codes and reset values of the long-press and multi-tap qualifier
// depends on nothing
`timescale 1ns / 1ps

package lpmt_pkg;

    localparam int CNT_W  = 16;
    localparam int PRS_W  = 8;
    localparam int MODE_W = 3;
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 16;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_READY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FULL   = 3'd3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_HOLD_TICKS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HOLD_LOCKOUT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TAP_TICKS     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TAP_LOCKOUT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESET_PRESSES = 3'd4;
    localparam logic [IDX_W-1:0] REG_TAP_WINDOW    = 3'd5;

    // register reset values
    localparam logic [CNT_W-1:0] RST_HOLD_TICKS    = 16'd1000;
    localparam logic [CNT_W-1:0] RST_HOLD_LOCKOUT  = 16'd5000;
    localparam logic [CNT_W-1:0] RST_TAP_TICKS     = 16'd100;
    localparam logic [CNT_W-1:0] RST_TAP_LOCKOUT   = 16'd500;
    localparam logic [PRS_W-1:0] RST_RESET_PRESSES = 8'd5;
    localparam logic [CNT_W-1:0] RST_TAP_WINDOW    = 16'd5000;

    localparam logic [PRS_W-1:0] PRESSES_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0] hold_ticks;
        logic [CNT_W-1:0] hold_lockout;
        logic [CNT_W-1:0] tap_ticks;
        logic [CNT_W-1:0] tap_lockout;
        logic [PRS_W-1:0] reset_presses;
        logic [CNT_W-1:0] tap_window;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] hold_count;
        logic             hold_latched;
        logic [CNT_W-1:0] hold_latch_count;
        logic [CNT_W-1:0] tap_count;
        logic             tap_latched;
        logic [CNT_W-1:0] tap_latch_count;
        logic [PRS_W-1:0] presses_seen;
        logic [CNT_W-1:0] window_count;
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              show_message;
        logic [MODE_W-1:0] next_mode;
        logic              refresh_display;
        logic              reset_request;
    } t_result;

endpackage

FILE: rtl/lpmt_step.sv
// one tick of the qualifier: next counter state and the result of the tick
// depends on lpmt_pkg
`timescale 1ns / 1ps

module lpmt_step
    import lpmt_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic              i_pressed,
    input  logic [MODE_W-1:0] i_mode,
    output t_state            o_state,
    output t_result           o_result
);

    t_state  s;
    t_result res;

    always_comb begin
        s   = i_state;
        res = '0;
        res.next_mode = i_mode;

        // long-press path
        if (i_pressed && !s.hold_latched) begin
            if (s.hold_count == i_cfg.hold_ticks) begin
                s.hold_latched = 1'b1;
                s.presses_seen = '0;
                res.refresh_display = 1'b1;
                case (i_mode) inside
                    MODE_NORMAL, MODE_FULL: begin
                        res.action       = ACT_CLOSE;
                        res.show_message = 1'b1;
                    end
                    MODE_CLOSE: begin
                        res.action       = ACT_OPEN;
                        res.show_message = 1'b1;
                    end
                    MODE_READY: begin
                        res.next_mode = MODE_NORMAL;
                    end
                    default: begin
                        res.action = ACT_NONE;
                    end
                endcase
            end else begin
                s.hold_count = s.hold_count + 1'b1;
            end
        end else begin
            s.hold_count = '0;
        end
        if (s.hold_latched) begin
            s.hold_latch_count = s.hold_latch_count + 1'b1;
            if (s.hold_latch_count >= i_cfg.hold_lockout) begin
                s.hold_latched     = 1'b0;
                s.hold_latch_count = '0;
            end
        end

        // tap path
        if (i_pressed && !s.tap_latched) begin
            if (s.tap_count == i_cfg.tap_ticks) begin
                s.tap_latched = 1'b1;
                if (s.presses_seen != PRESSES_MAX) begin
                    s.presses_seen = s.presses_seen + 1'b1;
                end
            end else begin
                s.tap_count = s.tap_count + 1'b1;
            end
        end else begin
            s.tap_count = '0;
        end
        if (s.tap_latched) begin
            s.tap_latch_count = s.tap_latch_count + 1'b1;
            if (s.tap_latch_count >= i_cfg.tap_lockout) begin
                s.tap_latched     = 1'b0;
                s.tap_latch_count = '0;
            end
        end

        // request is sampled before the window may clear the taps
        res.reset_request = (s.presses_seen >= i_cfg.reset_presses);

        // tap window
        if (s.presses_seen != '0) begin
            s.window_count = s.window_count + 1'b1;
            if (s.window_count >= i_cfg.tap_window) begin
                s.tap_latched     = 1'b0;
                s.tap_count       = '0;
                s.tap_latch_count = '0;
                s.presses_seen    = '0;
                s.window_count    = '0;
            end
        end

        o_state  = s;
        o_result = res;
    end

endmodule

FILE: rtl/long_press_and_multi_tap_qualifier.sv
// each input transaction reaches the result through the input register, then the result register
// throughput: one transaction per cycle unless stalled; the counter update is a
//   single pass of short compare and increment logic between the two registers
// reset: synchronous active-low i_rst_n clears all counters, latches and valids
//   and loads the configuration registers with their default values
// depends on lpmt_pkg, lpmt_step and long_press_and_multi_tap_qualifier_macros.svh
`timescale 1ns / 1ps
`include "long_press_and_multi_tap_qualifier_macros.svh"

module long_press_and_multi_tap_qualifier
    import lpmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_button_pressed,
    input  logic [MODE_W-1:0] i_mode,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ACT_W-1:0]  o_action,
    output logic              o_show_message,
    output logic [MODE_W-1:0] o_next_mode,
    output logic              o_refresh_display,
    output logic              o_reset_request
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks    <= RST_HOLD_TICKS;
            r_cfg.hold_lockout  <= RST_HOLD_LOCKOUT;
            r_cfg.tap_ticks     <= RST_TAP_TICKS;
            r_cfg.tap_lockout   <= RST_TAP_LOCKOUT;
            r_cfg.reset_presses <= RST_RESET_PRESSES;
            r_cfg.tap_window    <= RST_TAP_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_data;
                REG_HOLD_LOCKOUT:  r_cfg.hold_lockout  <= i_cfg_data;
                REG_TAP_TICKS:     r_cfg.tap_ticks     <= i_cfg_data;
                REG_TAP_LOCKOUT:   r_cfg.tap_lockout   <= i_cfg_data;
                REG_RESET_PRESSES: r_cfg.reset_presses <= i_cfg_data[PRS_W-1:0];
                REG_TAP_WINDOW:    r_cfg.tap_window    <= i_cfg_data;
                default: begin
                    // writes to unmapped indexes are dropped
                end
            endcase
        end
    end

    // input register stage
    logic              r_in_valid;
    logic              r_pressed;
    logic [MODE_W-1:0] r_mode;

    // result register stage
    logic              r_out_valid;
    t_result           r_result;

    // counter state, updated when an item moves into the result register
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;

    logic              w_out_free;
    logic              w_adv;
    logic              w_in_take;

    // result register can take a new item when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;
    // the item in the input register is processed this cycle
    assign w_adv      = r_in_valid && w_out_free;
    // input register can load when empty or being emptied
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    lpmt_step u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_pressed (r_pressed),
        .i_mode    (r_mode),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // control: valids and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_pressed <= i_button_pressed;
            r_mode    <= i_mode;
        end
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_result.action;
    assign o_show_message    = r_result.show_message;
    assign o_next_mode       = r_result.next_mode;
    assign o_refresh_display = r_result.refresh_display;
    assign o_reset_request   = r_result.reset_request;

    // any action comes only with a long-press fire and its prompt
    `LPMT_ASSERT_NOW(a_action_has_fire, i_clk, i_rst_n,
        r_out_valid && (r_result.action != ACT_NONE),
        r_result.refresh_display && r_result.show_message)
    // a held item in the input register is not lost
    `LPMT_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    // a processed item always lands in the result register
    `LPMT_ASSERT_NEXT(a_adv_lands, i_clk, i_rst_n, w_adv, r_out_valid)
    // the counter state moves only when an item is processed
    `LPMT_ASSERT_NEXT(a_state_quiet, i_clk, i_rst_n, !w_adv, $stable(r_state))

endmodule

FILE: sim/tb.sv
// self-checking testbench for long_press_and_multi_tap_qualifier: a tick-by-tick predictor
// scores every transaction, with directed, saturation, threshold-change and random phases
// depends on lpmt_pkg and the rtl of long_press_and_multi_tap_qualifier
`timescale 1ns / 1ps

module tb;
    import lpmt_pkg::*;

    // mode codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_NOT_CONN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SETUP    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_6   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_7   = 3'd7;
    // register indexes with no register behind them
    localparam logic [IDX_W-1:0]  REG_SPARE_6   = 3'd6;
    localparam logic [IDX_W-1:0]  REG_SPARE_7   = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_button_pressed = 1'b0;
    logic [MODE_W-1:0] i_mode = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ACT_W-1:0]  o_action;
    logic              o_show_message;
    logic [MODE_W-1:0] o_next_mode;
    logic              o_refresh_display;
    logic              o_reset_request;

    // typed-in expectation travels with the transaction it belongs to
    logic              r_typed = 1'b0;
    t_result           r_typed_res = '0;

    typedef struct packed {
        logic              button;
        logic [MODE_W-1:0] mode;
        logic              typed;
        t_result           res;
    } t_dir_row;

    t_cfg    qual_cfg;
    t_state  qual_st;
    t_result pending_results [$];
    int      n_mismatch = 0;
    int      idle_cycles = 0;
    int      send_gap_pct = 0;
    int      stall_pct = 0;

    long_press_and_multi_tap_qualifier u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_button_pressed  (i_button_pressed),
        .i_mode            (i_mode),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_action          (o_action),
        .o_show_message    (o_show_message),
        .o_next_mode       (o_next_mode),
        .o_refresh_display (o_refresh_display),
        .o_reset_request   (o_reset_request)
    );

    always #5 i_clk = ~i_clk;

    // one tick of the qualifier: long-press path, tap path, reset request, tap window
    function automatic t_result qualify_tick(input logic pressed,
                                             input logic [MODE_W-1:0] mode_in);
        t_result           r;
        logic [MODE_W-1:0] md;
        r  = '0;
        md = mode_in;

        if (pressed && !qual_st.hold_latched) begin
            if (qual_st.hold_count == qual_cfg.hold_ticks) begin
                qual_st.hold_latched = 1'b1;
                qual_st.presses_seen = '0;
                case (md)
                    MODE_NORMAL, MODE_FULL: begin
                        r.action       = ACT_CLOSE;
                        r.show_message = 1'b1;
                    end
                    MODE_CLOSE: begin
                        r.action       = ACT_OPEN;
                        r.show_message = 1'b1;
                    end
                    MODE_READY: begin
                        md = MODE_NORMAL;
                    end
                    default: ;
                endcase
                r.refresh_display = 1'b1;
            end else begin
                qual_st.hold_count = qual_st.hold_count + 1'b1;
            end
        end else begin
            qual_st.hold_count = '0;
        end
        // lockout already advances on the firing tick
        if (qual_st.hold_latched) begin
            qual_st.hold_latch_count = qual_st.hold_latch_count + 1'b1;
            if (qual_st.hold_latch_count >= qual_cfg.hold_lockout) begin
                qual_st.hold_latched     = 1'b0;
                qual_st.hold_latch_count = '0;
            end
        end

        if (pressed && !qual_st.tap_latched) begin
            if (qual_st.tap_count == qual_cfg.tap_ticks) begin
                qual_st.tap_latched = 1'b1;
                if (qual_st.presses_seen < PRESSES_MAX)
                    qual_st.presses_seen = qual_st.presses_seen + 1'b1;
            end else begin
                qual_st.tap_count = qual_st.tap_count + 1'b1;
            end
        end else begin
            qual_st.tap_count = '0;
        end
        if (qual_st.tap_latched) begin
            qual_st.tap_latch_count = qual_st.tap_latch_count + 1'b1;
            if (qual_st.tap_latch_count >= qual_cfg.tap_lockout) begin
                qual_st.tap_latched     = 1'b0;
                qual_st.tap_latch_count = '0;
            end
        end

        // request is sampled before the window may clear the taps
        r.reset_request = (qual_st.presses_seen >= qual_cfg.reset_presses);

        if (qual_st.presses_seen != '0) begin
            qual_st.window_count = qual_st.window_count + 1'b1;
            if (qual_st.window_count >= qual_cfg.tap_window) begin
                qual_st.tap_latched     = 1'b0;
                qual_st.tap_count       = '0;
                qual_st.tap_latch_count = '0;
                qual_st.presses_seen    = '0;
                qual_st.window_count    = '0;
            end
        end

        r.next_mode = md;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            n_mismatch++;
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // scoreboard: results are checked before the new transaction is scored,
    // register writes update the predictor's copy of the configuration
    always @(posedge i_clk) begin : score
        t_result got;
        t_result want;
        t_result tick_res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_action, o_show_message, o_next_mode, o_refresh_display,
                       o_reset_request};
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: result with none expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = pending_results.pop_front();
                    check_field("action", 8'(want.action), 8'(got.action));
                    check_field("show_message", 8'(want.show_message),
                                8'(got.show_message));
                    check_field("next_mode", 8'(want.next_mode), 8'(got.next_mode));
                    check_field("refresh_display", 8'(want.refresh_display),
                                8'(got.refresh_display));
                    check_field("reset_request", 8'(want.reset_request),
                                8'(got.reset_request));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HOLD_TICKS:    qual_cfg.hold_ticks    = i_cfg_data;
                    REG_HOLD_LOCKOUT:  qual_cfg.hold_lockout  = i_cfg_data;
                    REG_TAP_TICKS:     qual_cfg.tap_ticks     = i_cfg_data;
                    REG_TAP_LOCKOUT:   qual_cfg.tap_lockout   = i_cfg_data;
                    REG_RESET_PRESSES: qual_cfg.reset_presses = i_cfg_data[PRS_W-1:0];
                    REG_TAP_WINDOW:    qual_cfg.tap_window    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                tick_res = qualify_tick(i_button_pressed, i_mode);
                pending_results.push_back(r_typed ? r_typed_res : tick_res);
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("long_press_and_multi_tap_qualifier: mismatch");
            $finish;
        end
    end

    task automatic send_tick(input logic b, input logic [MODE_W-1:0] m,
                             input logic typed, input t_result res);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_button_pressed <= b;
        i_mode           <= m;
        r_typed          <= typed;
        r_typed_res      <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // sender holds off until every scored tick has its result back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // spare indexes first, reset_presses with junk in the upper byte
    task automatic write_cfg(input t_cfg c);
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        write_reg(REG_SPARE_6, DATA_W'($urandom_range(16'hffff)));
        write_reg(REG_SPARE_7, DATA_W'($urandom_range(16'hffff)));
        write_reg(REG_HOLD_TICKS, c.hold_ticks);
        write_reg(REG_HOLD_LOCKOUT, c.hold_lockout);
        write_reg(REG_TAP_TICKS, c.tap_ticks);
        write_reg(REG_TAP_LOCKOUT, c.tap_lockout);
        write_reg(REG_RESET_PRESSES, {junk, c.reset_presses});
        write_reg(REG_TAP_WINDOW, c.tap_window);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg make_cfg(input int h, input int hl, input int t, input int tl,
                                      input int rp, input int w);
        t_cfg c;
        c.hold_ticks    = CNT_W'(h);
        c.hold_lockout  = CNT_W'(hl);
        c.tap_ticks     = CNT_W'(t);
        c.tap_lockout   = CNT_W'(tl);
        c.reset_presses = PRS_W'(rp);
        c.tap_window    = CNT_W'(w);
        return c;
    endfunction

    function automatic t_cfg rand_cfg();
        return make_cfg($urandom_range(12), $urandom_range(15), $urandom_range(6),
                        $urandom_range(10), $urandom_range(6), $urandom_range(40));
    endfunction

    // mostly the four live modes, a quarter of the time an unused one
    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(3) == 0)
            return MODE_W'($urandom_range(7, 4));
        return MODE_W'($urandom_range(3));
    endfunction

    // presses sized around the current thresholds, releases, and some noise
    task automatic play_bursts(input int n_ticks);
        int                sent;
        int                len;
        int                rel;
        int                lim;
        logic [MODE_W-1:0] m;
        sent = 0;
        while (sent < n_ticks) begin
            m = pick_mode();
            if ($urandom_range(4) == 0) begin
                len = $urandom_range(12, 1);
                rel = 0;
                repeat (len) send_tick(1'($urandom_range(1)), pick_mode(), 1'b0, '0);
            end else begin
                lim = $urandom_range(1) ? int'(qual_cfg.hold_ticks)
                                        : int'(qual_cfg.tap_ticks);
                lim = (lim > 37) ? 40 : lim + 3;
                len = $urandom_range(lim, 1);
                rel = $urandom_range(8, 1);
                repeat (len) send_tick(1'b1, m, 1'b0, '0);
                repeat (rel) send_tick(1'b0, m, 1'b0, '0);
            end
            sent += len + rel;
            if ($urandom_range(59) == 0)
                drain();
        end
    endtask

    // directed ticks under a zero hold time and a one-tick lockout: every held tick
    // fires, and a zero press threshold keeps the reset request high
    t_dir_row dir_rows [20] = '{
        // after reset, button released
        '{1'b0, MODE_READY,    1'b1, {ACT_NONE,  1'b0, MODE_READY,    1'b0, 1'b1}},
        // fire in ready moves to normal
        '{1'b1, MODE_READY,    1'b1, {ACT_NONE,  1'b0, MODE_NORMAL,   1'b1, 1'b1}},
        '{1'b1, MODE_NORMAL,   1'b1, {ACT_CLOSE, 1'b1, MODE_NORMAL,   1'b1, 1'b1}},
        '{1'b1, MODE_CLOSE,    1'b1, {ACT_OPEN,  1'b1, MODE_CLOSE,    1'b1, 1'b1}},
        '{1'b1, MODE_FULL,     1'b1, {ACT_CLOSE, 1'b1, MODE_FULL,     1'b1, 1'b1}},
        // unused modes: refresh only, mode passes through
        '{1'b1, MODE_NOT_CONN, 1'b1, {ACT_NONE,  1'b0, MODE_NOT_CONN, 1'b1, 1'b1}},
        '{1'b1, MODE_SETUP,    1'b1, {ACT_NONE,  1'b0, MODE_SETUP,    1'b1, 1'b1}},
        '{1'b1, MODE_RSVD_6,   1'b1, {ACT_NONE,  1'b0, MODE_RSVD_6,   1'b1, 1'b1}},
        '{1'b1, MODE_RSVD_7,   1'b1, {ACT_NONE,  1'b0, MODE_RSVD_7,   1'b1, 1'b1}},
        '{1'b0, MODE_RSVD_7,   1'b1, {ACT_NONE,  1'b0, MODE_RSVD_7,   1'b0, 1'b1}},
        '{1'b1, MODE_NORMAL,   1'b0, '0},
        '{1'b1, MODE_CLOSE,    1'b0, '0},
        '{1'b1, MODE_FULL,     1'b0, '0},
        '{1'b0, MODE_READY,    1'b0, '0},
        '{1'b1, MODE_READY,    1'b0, '0},
        '{1'b1, MODE_READY,    1'b0, '0},
        '{1'b0, MODE_CLOSE,    1'b0, '0},
        '{1'b1, MODE_FULL,     1'b0, '0},
        '{1'b1, MODE_NOT_CONN, 1'b0, '0},
        '{1'b0, MODE_NORMAL,   1'b0, '0}
    };

    initial begin
        qual_cfg = '{RST_HOLD_TICKS, RST_HOLD_LOCKOUT, RST_TAP_TICKS, RST_TAP_LOCKOUT,
                     RST_RESET_PRESSES, RST_TAP_WINDOW};
        qual_st  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles a little, receiver a lot
        send_gap_pct = 22;
        stall_pct    = 75;

        write_cfg(make_cfg(0, 1, 2, 3, 0, 65535));
        foreach (dir_rows[i])
            send_tick(dir_rows[i].button, dir_rows[i].mode, dir_rows[i].typed,
                      dir_rows[i].res);

        // zero tap time and lockout score a tap on every held tick: press count saturates
        drain();
        write_cfg(make_cfg(65535, 65535, 0, 0, 255, 65535));
        repeat (300) send_tick(1'b1, pick_mode(), 1'b0, '0);
        repeat (4) send_tick(1'b0, pick_mode(), 1'b0, '0);

        repeat (2) begin
            drain();
            write_cfg(rand_cfg());
            play_bursts(140);
        end

        // roles swapped
        drain();
        send_gap_pct = 75;
        stall_pct    = 22;

        write_cfg(make_cfg(0, 0, 0, 0, 0, 0));
        play_bursts(120);

        // start both lockouts and the tap window, then lower them below the running counts
        drain();
        write_cfg(make_cfg(1, 65535, 1, 65535, 3, 65535));
        repeat (12) send_tick(1'b1, MODE_NORMAL, 1'b0, '0);
        drain();
        write_cfg(make_cfg(65535, 2, 65535, 2, 1, 3));
        repeat (30) send_tick(1'b1, pick_mode(), 1'b0, '0);

        repeat (2) begin
            drain();
            write_cfg(rand_cfg());
            play_bursts(140);
        end

        // no idling on either side
        drain();
        send_gap_pct = 0;
        stall_pct    = 0;

        // hold and tap thresholds lowered below running counts: counters run on past them
        write_cfg(make_cfg(40, 2, 40, 2, 1, 3));
        repeat (20) send_tick(1'b1, pick_mode(), 1'b0, '0);
        drain();
        write_cfg(make_cfg(4, 2, 6, 2, 1, 3));
        repeat (30) send_tick(1'b1, pick_mode(), 1'b0, '0);
        repeat (4) send_tick(1'b0, pick_mode(), 1'b0, '0);

        drain();
        write_cfg(make_cfg(1, 1, 1, 1, 1, 1));
        play_bursts(150);

        drain();
        write_cfg(make_cfg(65535, 65535, 65535, 65535, 255, 65535));
        play_bursts(120);

        repeat (2) begin
            drain();
            write_cfg(rand_cfg());
            play_bursts(140);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("long_press_and_multi_tap_qualifier: match");
        else
            $display("long_press_and_multi_tap_qualifier: mismatch");
        $finish;
    end

endmodule
